/* rtl/bcg_pkg.sv */
`timescale 1ns / 1ps
// bcg_pkg: shared constants, width helpers and front-end state type for the
// bar-graph cell generator. No dependencies.
package bcg_pkg;

  localparam int DATA_W        = 16;  // level, peak and full-scale readings
  localparam int CFG_W         = 6;   // cell count register
  localparam int CODE_W        = 3;   // character code
  localparam int CELL_COUNT_RST = 16;
  localparam int MAX_CELLS_DEF = 40;
  localparam int PIX_PER_CELL  = 6;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CODE_W-1:0] CODE_EMPTY = 3'd0;
  localparam logic [CODE_W-1:0] CODE_FULL  = 3'd5;
  localparam logic [CODE_W-1:0] CODE_PEAK  = 3'd6;

  // bits needed to hold a cell count up to max_cells
  function automatic int cell_w(input int max_cells);
    return $clog2(max_cells + 1);
  endfunction

  // bits of a pixel count up to 6 * max_cells; also divider quotient width
  function automatic int quo_w(input int max_cells);
    return $clog2(PIX_PER_CELL * max_cells + 1);
  endfunction

  // job word: {fs_zero, peak_ok, n, pix, peak_idx}
  function automatic int job_w(input int max_cells);
    return 2 + cell_w(max_cells) + 2 * quo_w(max_cells);
  endfunction

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_PUSH
  } front_state_t;

endpackage

/* rtl/bcg_fifo.sv */
`timescale 1ns / 1ps
// bcg_fifo: small flop-based queue between the front and back ends.
// No package dependencies.
module bcg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/bcg_front.sv */
`timescale 1ns / 1ps
// bcg_front: accepts readings, scales them and runs two restoring dividers
// (bar pixels and peak cell index). Depends on bcg_pkg.
module bcg_front #(
  parameter int MAX_CELLS = bcg_pkg::MAX_CELLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bcg_pkg::CFG_W-1:0]   cell_count,
  input  logic                        push,
  output logic                        full,
  input  logic [bcg_pkg::DATA_W-1:0]  level,
  input  logic [bcg_pkg::DATA_W-1:0]  peak_level,
  input  logic [bcg_pkg::DATA_W-1:0]  full_scale,
  output logic                        q_push,
  output logic [bcg_pkg::job_w(MAX_CELLS)-1:0] q_data,
  input  logic                        q_full
);

  localparam int DW    = bcg_pkg::DATA_W;
  localparam int CW    = bcg_pkg::cell_w(MAX_CELLS);
  localparam int QW    = bcg_pkg::quo_w(MAX_CELLS);
  localparam int NUM_W = DW + QW;
  localparam int SCW   = $clog2(QW + 1);

  bcg_pkg::front_state_t state, state_next;

  logic [DW-1:0]  lvl;
  logic [DW-1:0]  pk;
  logic [DW-1:0]  fs;
  logic [CW-1:0]  n;
  logic [CW-1:0]  n_in;
  logic           accept;
  logic [DW-1:0]  lvl_clamped;
  logic [QW-1:0]  n6;
  logic [NUM_W-1:0] pix_num;
  logic [NUM_W-1:0] pk_num;

  // divider registers: partial remainder plus shifting numerator/quotient
  logic [DW-1:0]  rem_x;
  logic [QW-1:0]  lo_x;
  logic [DW-1:0]  rem_p;
  logic [QW-1:0]  lo_p;
  logic [SCW-1:0] step;
  logic [DW:0]    rs_x;
  logic [DW:0]    rs_p;
  logic           ge_x;
  logic           ge_p;

  assign n_in = (int'(cell_count) > MAX_CELLS) ? CW'(MAX_CELLS) : CW'(cell_count);
  assign full   = (state != bcg_pkg::F_IDLE);
  assign accept = push && !full;

  assign lvl_clamped = (lvl > fs) ? fs : lvl;
  assign n6      = QW'(n) * QW'(bcg_pkg::PIX_PER_CELL);
  assign pix_num = NUM_W'(lvl_clamped) * NUM_W'(n6);
  assign pk_num  = NUM_W'(pk) * NUM_W'(n);

  assign rs_x = {rem_x, lo_x[QW-1]};
  assign rs_p = {rem_p, lo_p[QW-1]};
  assign ge_x = (rs_x >= {1'b0, fs});
  assign ge_p = (rs_p >= {1'b0, fs});

  assign q_data = {(fs == '0), (pk < fs), n, lo_x, lo_p};

  always_comb begin
    state_next = state;
    q_push     = 1'b0;
    unique case (state)
      bcg_pkg::F_IDLE: begin
        if (accept && (n_in != '0)) begin
          state_next = bcg_pkg::F_MUL;
        end
      end
      bcg_pkg::F_MUL: begin
        state_next = bcg_pkg::F_DIV;
      end
      bcg_pkg::F_DIV: begin
        if (step == SCW'(QW - 1)) begin
          state_next = bcg_pkg::F_PUSH;
        end
      end
      bcg_pkg::F_PUSH: begin
        q_push = !q_full;
        if (!q_full) begin
          state_next = bcg_pkg::F_IDLE;
        end
      end
      default: state_next = bcg_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcg_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lvl <= level;
      pk  <= peak_level;
      fs  <= full_scale;
      n   <= n_in;
    end
    if (state == bcg_pkg::F_MUL) begin
      // quotient fits QW bits, so the top bits start as the remainder
      rem_x <= pix_num[NUM_W-1:QW];
      lo_x  <= pix_num[QW-1:0];
      rem_p <= pk_num[NUM_W-1:QW];
      lo_p  <= pk_num[QW-1:0];
      step  <= '0;
    end else if (state == bcg_pkg::F_DIV) begin
      rem_x <= ge_x ? DW'(rs_x - {1'b0, fs}) : rs_x[DW-1:0];
      rem_p <= ge_p ? DW'(rs_p - {1'b0, fs}) : rs_p[DW-1:0];
      if (QW > 1) begin
        lo_x <= {lo_x[QW-2:0], ge_x};
        lo_p <= {lo_p[QW-2:0], ge_p};
      end else begin
        lo_x <= QW'(ge_x);
        lo_p <= QW'(ge_p);
      end
      step <= step + 1'b1;
    end
  end

endmodule

/* rtl/bcg_back.sv */
`timescale 1ns / 1ps
// bcg_back: walks the cells of one queued job and drives the output register.
// Depends on bcg_pkg.
module bcg_back #(
  parameter int MAX_CELLS = bcg_pkg::MAX_CELLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bcg_pkg::job_w(MAX_CELLS)-1:0] q_data,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic                        empty,
  input  logic                        pop,
  output logic [bcg_pkg::CODE_W-1:0]  char_code,
  output logic                        last_cell
);

  localparam int CW = bcg_pkg::cell_w(MAX_CELLS);
  localparam int QW = bcg_pkg::quo_w(MAX_CELLS);
  localparam int JW = bcg_pkg::job_w(MAX_CELLS);

  logic          busy;
  logic          fs_zero;
  logic          peak_ok;
  logic [CW-1:0] n;
  logic [QW-1:0] pix;
  logic [QW-1:0] pidx;
  logic [CW-1:0] idx;
  logic [QW-1:0] start;

  logic          ov;
  logic          emit;
  logic          last;
  logic          take;
  logic          is_full;
  logic          is_past;
  logic [bcg_pkg::CODE_W-1:0] code;

  assign empty   = !ov;
  assign emit    = busy && (!ov || pop);
  assign last    = (idx == CW'(n - 1'b1));
  assign take    = !q_empty && (!busy || (emit && last));
  assign q_pop   = take;

  assign is_full = (({1'b0, start} + (QW + 1)'(bcg_pkg::PIX_PER_CELL)) <= {1'b0, pix});
  assign is_past = (start > pix);

  always_comb begin
    if (fs_zero) begin
      code = bcg_pkg::CODE_EMPTY;
    end else if (is_full) begin
      code = bcg_pkg::CODE_FULL;
    end else if (is_past) begin
      code = (peak_ok && (QW'(idx) == pidx)) ? bcg_pkg::CODE_PEAK : bcg_pkg::CODE_EMPTY;
    end else begin
      // partial cell: pixels left over, always below six here
      code = bcg_pkg::CODE_W'(pix - start);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ov   <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
      end else if (emit && last) begin
        busy <= 1'b0;
      end
      if (emit) begin
        ov <= 1'b1;
      end else if (pop) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fs_zero <= q_data[JW-1];
      peak_ok <= q_data[JW-2];
      n       <= q_data[2*QW+CW-1:2*QW];
      pix     <= q_data[2*QW-1:QW];
      pidx    <= q_data[QW-1:0];
      idx     <= '0;
      start   <= '0;
    end else if (emit) begin
      idx   <= idx + 1'b1;
      start <= start + QW'(bcg_pkg::PIX_PER_CELL);
    end
    if (emit) begin
      char_code <= code;
      last_cell <= last;
    end
  end

endmodule

/* rtl/bargraph_cell_generator_with_peak_unit.sv */
`timescale 1ns / 1ps
// bargraph_cell_generator_with_peak_unit: top level of the bar-graph cell
// generator. Depends on bcg_pkg, bcg_front, bcg_fifo and bcg_back.
//
// Usage:
//   Input side is a queue: drive level, peak_level and full_scale and raise
//   push; a transfer happens on a clock edge with push high and full low.
//   Output side is a queue too: while empty is low, char_code/last_cell hold
//   the oldest cell; a transfer happens on an edge with pop high.
//   One input transfer yields one output transfer per display cell, first
//   cell first; last_cell marks the final one. A cell count of zero yields
//   nothing.
//   cfg_we/cfg_wdata write the cell count (saturated to MAX_CELLS); write it
//   only while no item is in flight.
// Timing:
//   The first cell passes the input registers, the multiply state, the QW
//   divider steps, where QW = clog2(6*MAX_CELLS+1) (QW is 8 at 40 cells),
//   the job queue push, the back end's job registers and the output register.
//   The front end takes no new item until its last job is pushed (one bit
//   per cycle from two restoring dividers); the back end emits one cell per
//   cycle while the output register is empty or being popped.
// Reset: synchronous; clears the queues, the dividers' control and sets the
//   cell count to 16.
// Stall: when pop is held low the output register holds, the back end stops,
//   the job queue fills and then the front end holds full high in its push state.
module bargraph_cell_generator_with_peak_unit #(
  parameter int MAX_CELLS = bcg_pkg::MAX_CELLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [bcg_pkg::CFG_W-1:0]   cfg_wdata,
  // input queue
  input  logic                        push,
  output logic                        full,
  input  logic [bcg_pkg::DATA_W-1:0]  level,
  input  logic [bcg_pkg::DATA_W-1:0]  peak_level,
  input  logic [bcg_pkg::DATA_W-1:0]  full_scale,
  // result queue
  output logic                        empty,
  input  logic                        pop,
  output logic [bcg_pkg::CODE_W-1:0]  char_code,
  output logic                        last_cell
);

  localparam int JW = bcg_pkg::job_w(MAX_CELLS);

  logic [bcg_pkg::CFG_W-1:0] cell_count;

  // job queue between the dividers and the cell walker
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  logic [JW-1:0] q_wdata;
  logic [JW-1:0] q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count <= bcg_pkg::CFG_W'(bcg_pkg::CELL_COUNT_RST);
    end else if (cfg_we) begin
      cell_count <= cfg_wdata;
    end
  end

  bcg_front #(
    .MAX_CELLS (MAX_CELLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cell_count (cell_count),
    .push       (push),
    .full       (full),
    .level      (level),
    .peak_level (peak_level),
    .full_scale (full_scale),
    .q_push     (q_push),
    .q_data     (q_wdata),
    .q_full     (q_full)
  );

  bcg_fifo #(
    .WIDTH (JW),
    .DEPTH (bcg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  bcg_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .char_code (char_code),
    .last_cell (last_cell)
  );

  // front end only writes a job when the queue has room
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job queue written while full");

  // back end only takes a job that is there
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job queue read while empty");

  // coming out of reset both sides are quiet
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (empty && !full))
    else $error("block not idle after reset");

  // a waiting cell never carries a code above the peak marker
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (char_code <= bcg_pkg::CODE_PEAK))
    else $error("invalid character code");

endmodule
